[rtl/peak_rms_level_meter_macros.svh]
// Assertion macros shared by the checker of the level meter.
// Depends on nothing; the asserting module provides aclk and aresetn.
`ifndef PEAK_RMS_LEVEL_METER_MACROS_SVH
`define PEAK_RMS_LEVEL_METER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PRL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PRL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/prl_pkg.sv]
// Package of the peak / RMS level meter: fixed widths, constants and the sequencer states.
// Used by the top level, the checker and the testbench; depends on nothing.
package prl_pkg;

    // Accumulator and register widths.
    localparam int SUM_W      = 56;
    localparam int INTERVAL_W = 14;
    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 14'd50;

    // Result fields.
    localparam int LEVEL_W   = 10;
    localparam int MAG_W     = 9;
    localparam logic [MAG_W-1:0] MAG_FLOOR = 9'd400;
    localparam int OV_W      = 6;
    localparam logic [OV_W-1:0] OV_MAX = 6'd63;
    localparam int M_TDATA_W = 32;

    // Shared multiplier and log datapath.
    localparam int MUL_W     = 32;
    localparam int PROD_W    = 64;
    localparam int FRAC_BITS = 16;
    localparam int ITER_W    = 4;
    localparam logic [ITER_W-1:0] ITER_LAST = 4'd15;
    localparam logic [MUL_W-1:0] LOG_K = 32'd1578264;    // 80*log10(2) in Q16
    localparam logic [PROD_W-1:0] ROUND_HALF = 64'h0000_0000_8000_0000;
    localparam logic [PROD_W-1:0] OV_LIMIT = 64'd1000;

    // Tick sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DRAIN,
        ST_DIV,
        ST_LVL,
        ST_NORM,
        ST_SQ,
        ST_SQA,
        ST_NEG,
        ST_KMUL,
        ST_ROUND,
        ST_PSQ,
        ST_PLD,
        ST_OV,
        ST_FIN
    } state_t;

endpackage

[rtl/prl_div.sv]
// Restoring divider of the level meter: one quotient bit per cycle.
// Depends on nothing outside this file.
module prl_div #(
    parameter int DIVIDEND_W = 56,
    parameter int DIVISOR_W  = 24
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  dvs_reg, dvs_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;

    logic [DIVISOR_W:0]    shifted;
    logic [DIVISOR_W:0]    diff;
    logic                  fits;

    // One restoring step: shift in the next dividend bit and try to subtract.
    always_comb begin
        shifted = {rem_reg, quo_reg[DIVIDEND_W-1]};
        diff    = shifted - {1'b0, dvs_reg};
        fits    = (shifted >= {1'b0, dvs_reg});
    end

    // Step control: load on start, then one bit a cycle until all bits are done.
    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
            rem_next = fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(DIVIDEND_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state is reset; the datapath is not.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        cnt_reg <= cnt_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[rtl/peak_rms_level_meter.sv]
// Peak / RMS audio level meter in 1/8 dBFS (this file: top level; uses prl_pkg and prl_div).
// Sample items (s_tuser = 0) are taken one per cycle while s_tready is high and update the
// absolute peak, the saturating sum of squares and the saturating sample count; they give no
// result. A tick item (s_tuser = 1) gives one result item, and s_tready is low while it is
// processed: the sample pipeline is drained, the restoring divider forms sum / count at one
// quotient bit per cycle (skipped when no sample came in), then for RMS and for peak a
// one-bit-a-cycle normalizing shift and 16 squaring passes, each a squaring state and a
// fraction-bit state, through the shared 32x32 multiplier, then scaling, overload update and
// output. A result waits in the output register without blocking samples; a further tick stalls
// at its last step until that result is taken. interval_ms may be written while the meter is idle.
module peak_rms_level_meter
    import prl_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int COUNT_BITS  = 24,
    localparam int S_TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration: interval_ms.
    input  logic                  cfg_wr_en,
    input  logic [INTERVAL_W-1:0] cfg_wr_data,
    // Input items.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [SAMPLE_BITS-1:0] sample, rest zero
    input  logic                  s_tuser,   // [0] cmd
    // Result items.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [9:0] rms_db, [19:10] peak_db, [25:20] overload
    output logic                  m_tuser    // [0] changed
);

    localparam int SQ_W    = 2 * SAMPLE_BITS;
    localparam int PW      = (2 * SAMPLE_BITS - 1 > SUM_W) ? 2 * SAMPLE_BITS - 1 : SUM_W;
    localparam int ADD_W   = ((SQ_W > SUM_W) ? SQ_W : SUM_W) + 1;
    localparam int SH_W    = $clog2(PW);
    localparam int FS_LOG2 = 2 * SAMPLE_BITS - 2;
    localparam int DIFF_W  = $clog2(2 * SAMPLE_BITS - 1);
    localparam int NEG_W   = DIFF_W + FRAC_BITS;
    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    // Sequencer.
    state_t state_reg, state_next;

    // Accumulators and stored levels.
    logic [SAMPLE_BITS-1:0] peak_reg, peak_next;
    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic [COUNT_BITS-1:0]  count_reg, count_next;
    logic [OV_W-1:0]        ov_count_reg, ov_count_next;
    logic [MAG_W-1:0]       last_rms_reg, last_rms_next;
    logic [MAG_W-1:0]       last_peak_reg, last_peak_next;
    logic [INTERVAL_W-1:0]  interval_reg, interval_next;

    // Sample pipeline: absolute value, then square, then add.
    logic [SAMPLE_BITS-1:0] abs_reg, abs_next;
    logic                   abs_vld_reg, abs_vld_next;
    logic                   sq_vld_reg, sq_vld_next;

    // Shared multiplier.
    logic [MUL_W-1:0]       mul_a, mul_b;
    logic [PROD_W-1:0]      prod_reg, prod_next;
    logic                   prod_load;

    // Level datapath.
    logic [PW-1:0]          x_reg, x_next;
    logic [SH_W-1:0]        sh_cnt_reg, sh_cnt_next;
    logic [SH_W-1:0]        e_reg, e_next;
    logic [MUL_W-1:0]       y_reg, y_next;
    logic [FRAC_BITS-1:0]   frac_reg, frac_next;
    logic [ITER_W-1:0]      iter_reg, iter_next;
    logic [NEG_W-1:0]       neg_reg, neg_next;
    logic [MAG_W-1:0]       rms_mag_reg, rms_mag_next;
    logic [MAG_W-1:0]       peak_mag_reg, peak_mag_next;
    logic                   which_peak_reg, which_peak_next;
    logic [OV_W-1:0]        ov_new_reg, ov_new_next;

    // Output register.
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]   m_tdata_reg, m_tdata_next;
    logic                   m_tuser_reg, m_tuser_next;

    // Helpers.
    logic                   in_acc;
    logic [SAMPLE_BITS-1:0] raw;
    logic [SAMPLE_BITS-1:0] raw_abs;
    logic [ADD_W-1:0]       sum_wide;
    logic                   drained;
    logic                   div_start;
    logic                   div_done;
    logic [SUM_W-1:0]       div_quo;
    logic [SH_W-1:0]        e_val;
    logic [SH_W-1:0]        diff_full;
    logic [NEG_W-1:0]       neg_val;
    logic [PROD_W-1:0]      rnd;
    logic [MAG_W-1:0]       round_mag;
    logic                   lvl_done;
    logic [MAG_W-1:0]       lvl_mag;
    state_t                 after_lvl;
    logic [OV_W-1:0]        ov_inc;
    logic [OV_W-1:0]        ov_final;
    logic                   out_free;
    logic                   changed;
    logic [LEVEL_W-1:0]     rms_level;
    logic [LEVEL_W-1:0]     peak_level;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign raw      = s_tdata[SAMPLE_BITS-1:0];
    assign raw_abs  = raw[SAMPLE_BITS-1] ? (~raw + SAMPLE_BITS'(1)) : raw;
    assign drained  = !abs_vld_reg && !sq_vld_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    // Bit-serial divider for the mean square.
    assign div_start = (state_reg == ST_DRAIN) && drained && (count_reg != '0);

    prl_div #(
        .DIVIDEND_W(SUM_W),
        .DIVISOR_W (COUNT_BITS)
    ) u_prl_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .dividend(sum_reg),
        .divisor (count_reg),
        .done    (div_done),
        .quotient(div_quo)
    );

    // Shared multiplier: the sequencer owns it during a tick, the sample squarer otherwise.
    always_comb begin
        mul_a     = MUL_W'(abs_reg);
        mul_b     = MUL_W'(abs_reg);
        prod_load = abs_vld_reg;
        case (state_reg)
            ST_SQ: begin
                mul_a     = y_reg;
                mul_b     = y_reg;
                prod_load = 1'b1;
            end
            ST_KMUL: begin
                mul_a     = MUL_W'(neg_reg);
                mul_b     = LOG_K;
                prod_load = 1'b1;
            end
            ST_PSQ: begin
                mul_a     = MUL_W'(peak_reg);
                mul_b     = MUL_W'(peak_reg);
                prod_load = 1'b1;
            end
            ST_OV: begin
                mul_a     = MUL_W'(ov_inc);
                mul_b     = MUL_W'(interval_reg);
                prod_load = 1'b1;
            end
            default: ;
        endcase
        prod_next = prod_load ? (mul_a * mul_b) : prod_reg;
    end

    // Level step helpers: exponent, log magnitude, rounding and the early exits.
    always_comb begin
        e_val     = SH_W'(PW - 1) - sh_cnt_reg;
        diff_full = SH_W'(FS_LOG2) - e_reg;
        neg_val   = {diff_full[DIFF_W-1:0], {FRAC_BITS{1'b0}}};
        rnd       = prod_reg + ROUND_HALF;
        round_mag = (rnd[PROD_W-1:32] > 32'(MAG_FLOOR)) ? MAG_FLOOR : rnd[32+MAG_W-1:32];
        after_lvl = which_peak_reg ? ST_OV : ST_PSQ;
        lvl_done  = 1'b0;
        lvl_mag   = '0;
        case (state_reg)
            ST_LVL: begin
                if (x_reg == '0) begin
                    lvl_done = 1'b1;
                    lvl_mag  = MAG_FLOOR;
                end
            end
            ST_NORM: begin
                // Power above full scale reads as 0 dB.
                if (x_reg[PW-1] && (e_val > SH_W'(FS_LOG2))) begin
                    lvl_done = 1'b1;
                end
            end
            ST_NEG: begin
                if (NEG_W'(frac_reg) > neg_val) begin
                    lvl_done = 1'b1;
                end
            end
            ST_ROUND: begin
                lvl_done = 1'b1;
                lvl_mag  = round_mag;
            end
            default: ;
        endcase
    end

    // Overload hold counter for this tick.
    always_comb begin
        if (peak_reg[SAMPLE_BITS-1]) begin
            ov_inc = OV_W'(1);
        end else if ((ov_count_reg != '0) && (ov_count_reg != OV_MAX)) begin
            ov_inc = ov_count_reg + OV_W'(1);
        end else begin
            ov_inc = ov_count_reg;
        end
        ov_final   = (prod_reg >= OV_LIMIT) ? '0 : ov_new_reg;
        changed    = (rms_mag_reg != last_rms_reg) || (peak_mag_reg != last_peak_reg) ||
                     (ov_final != ov_count_reg);
        rms_level  = LEVEL_W'(0) - LEVEL_W'(rms_mag_reg);
        peak_level = LEVEL_W'(0) - LEVEL_W'(peak_mag_reg);
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc && s_tuser) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (drained) begin
                    state_next = (count_reg == '0) ? ST_PSQ : ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_LVL;
                end
            end
            ST_LVL: begin
                state_next = lvl_done ? after_lvl : ST_NORM;
            end
            ST_NORM: begin
                if (lvl_done) begin
                    state_next = after_lvl;
                end else if (x_reg[PW-1]) begin
                    state_next = ST_SQ;
                end
            end
            ST_SQ:    state_next = ST_SQA;
            ST_SQA:   state_next = (iter_reg == ITER_LAST) ? ST_NEG : ST_SQ;
            ST_NEG:   state_next = lvl_done ? after_lvl : ST_KMUL;
            ST_KMUL:  state_next = ST_ROUND;
            ST_ROUND: state_next = after_lvl;
            ST_PSQ:   state_next = ST_PLD;
            ST_PLD:   state_next = ST_LVL;
            ST_OV:    state_next = ST_FIN;
            ST_FIN: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Datapath and register updates per state.
    always_comb begin
        peak_next       = peak_reg;
        sum_next        = sum_reg;
        count_next      = count_reg;
        ov_count_next   = ov_count_reg;
        last_rms_next   = last_rms_reg;
        last_peak_next  = last_peak_reg;
        interval_next   = cfg_wr_en ? cfg_wr_data : interval_reg;
        abs_next        = abs_reg;
        abs_vld_next    = in_acc && !s_tuser;
        sq_vld_next     = abs_vld_reg;
        x_next          = x_reg;
        sh_cnt_next     = sh_cnt_reg;
        e_next          = e_reg;
        y_next          = y_reg;
        frac_next       = frac_reg;
        iter_next       = iter_reg;
        neg_next        = neg_reg;
        rms_mag_next    = rms_mag_reg;
        peak_mag_next   = peak_mag_reg;
        which_peak_next = which_peak_reg;
        ov_new_next     = ov_new_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        sum_wide        = ADD_W'(sum_reg) + ADD_W'(prod_reg[SQ_W-1:0]);

        // Sample item: peak and count at once; the square passes abs_reg and prod_reg before the add.
        if (in_acc && !s_tuser) begin
            abs_next = raw_abs;
            if (raw_abs > peak_reg) begin
                peak_next = raw_abs;
            end
            if (count_reg != '1) begin
                count_next = count_reg + COUNT_BITS'(1);
            end
        end
        if (sq_vld_reg) begin
            sum_next = (sum_wide > ADD_W'(SUM_MAX)) ? SUM_MAX : sum_wide[SUM_W-1:0];
        end

        // A finished level goes to the RMS or the peak slot.
        if (lvl_done) begin
            if (which_peak_reg) begin
                peak_mag_next = lvl_mag;
            end else begin
                rms_mag_next = lvl_mag;
            end
        end

        case (state_reg)
            ST_DRAIN: begin
                if (drained && (count_reg == '0)) begin
                    rms_mag_next = MAG_FLOOR;
                end
            end
            ST_DIV: begin
                x_next          = PW'(div_quo);
                which_peak_next = 1'b0;
            end
            ST_LVL: begin
                sh_cnt_next = '0;
            end
            ST_NORM: begin
                // Shift left until the leading one reaches the top bit.
                if (x_reg[PW-1]) begin
                    e_next    = e_val;
                    y_next    = {1'b0, x_reg[PW-1 -: MUL_W-1]};
                    frac_next = '0;
                    iter_next = '0;
                end else begin
                    x_next      = {x_reg[PW-2:0], 1'b0};
                    sh_cnt_next = sh_cnt_reg + SH_W'(1);
                end
            end
            ST_SQA: begin
                // One fraction bit of log2 per squaring.
                frac_next = {frac_reg[FRAC_BITS-2:0], prod_reg[61]};
                y_next    = prod_reg[61] ? {1'b0, prod_reg[61:31]} : prod_reg[61:30];
                iter_next = iter_reg + ITER_W'(1);
            end
            ST_NEG: begin
                neg_next = neg_val - NEG_W'(frac_reg);
            end
            ST_PLD: begin
                x_next          = PW'(prod_reg);
                which_peak_next = 1'b1;
            end
            ST_OV: begin
                ov_new_next = ov_inc;
            end
            ST_FIN: begin
                if (out_free) begin
                    m_tvalid_next  = 1'b1;
                    m_tdata_next   = M_TDATA_W'({ov_final, peak_level, rms_level});
                    m_tuser_next   = changed;
                    last_rms_next  = rms_mag_reg;
                    last_peak_next = peak_mag_reg;
                    ov_count_next  = ov_final;
                    peak_next      = '0;
                    sum_next       = '0;
                    count_next     = '0;
                end
            end
            default: ;
        endcase
    end

    // Control and architectural state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            peak_reg      <= '0;
            sum_reg       <= '0;
            count_reg     <= '0;
            ov_count_reg  <= '0;
            last_rms_reg  <= MAG_FLOOR;
            last_peak_reg <= MAG_FLOOR;
            interval_reg  <= INTERVAL_RESET;
            abs_vld_reg   <= 1'b0;
            sq_vld_reg    <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            peak_reg      <= peak_next;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            ov_count_reg  <= ov_count_next;
            last_rms_reg  <= last_rms_next;
            last_peak_reg <= last_peak_next;
            interval_reg  <= interval_next;
            abs_vld_reg   <= abs_vld_next;
            sq_vld_reg    <= sq_vld_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        abs_reg        <= abs_next;
        prod_reg       <= prod_next;
        x_reg          <= x_next;
        sh_cnt_reg     <= sh_cnt_next;
        e_reg          <= e_next;
        y_reg          <= y_next;
        frac_reg       <= frac_next;
        iter_reg       <= iter_next;
        neg_reg        <= neg_next;
        rms_mag_reg    <= rms_mag_next;
        peak_mag_reg   <= peak_mag_next;
        which_peak_reg <= which_peak_next;
        ov_new_reg     <= ov_new_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

[rtl/prl_chk.sv]
// Port-level checker of the level meter, attached to the top level by a bind.
// Depends on prl_pkg and peak_rms_level_meter_macros.svh.
`include "peak_rms_level_meter_macros.svh"

module prl_chk
    import prl_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    localparam int S_TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  cfg_wr_en,
    input logic [INTERVAL_W-1:0] cfg_wr_data,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [S_TDATA_W-1:0]  s_tdata,
    input logic                  s_tuser,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [M_TDATA_W-1:0]  m_tdata,
    input logic                  m_tuser
);

    // A stalled result keeps its payload.
    `PRL_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

    // Both levels are at or below full scale.
    `PRL_ASSERT_NOW(a_level_sign, m_tvalid, (m_tdata[9] || m_tdata[9:0] == 10'd0) && (m_tdata[19] || m_tdata[19:10] == 10'd0), "positive level on output")

    // A tick item makes the meter busy in the next cycle.
    `PRL_ASSERT_NEXT(a_tick_busy, s_tvalid && s_tready && s_tuser, !s_tready, "meter ready right after a tick")

    // Sample items never stall the input.
    `PRL_ASSERT_NEXT(a_sample_flow, s_tvalid && s_tready && !s_tuser, s_tready, "sample item stalled the input")

    // A new result only comes out of tick processing.
    `PRL_ASSERT_NOW(a_result_from_tick, $rose(m_tvalid), !$past(s_tready), "result without a tick")

endmodule

bind peak_rms_level_meter prl_chk #(.SAMPLE_BITS(SAMPLE_BITS)) u_prl_chk (.*);

[tb/tb.sv]
`timescale 1ns / 100ps
// Testbench of the peak / RMS level meter: directed and random sample and tick items
// are checked, one result item at a time, against a behavioral model of the meter.
// Depends on prl_pkg and peak_rms_level_meter.
module tb;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    localparam int unsigned     FLOOR_MAG     = 400;           // -50 dB in 1/8 dB
    localparam int unsigned     FS_LOG2       = 30;            // log2 of full-scale power
    localparam longint unsigned LOG_SCALE_Q16 = 1578264;       // 80*log10(2) in Q16
    localparam longint unsigned ENERGY_MAX    = (64'd1 << 56) - 1;
    localparam int unsigned     COUNT_MAX     = (1 << 24) - 1;
    localparam int unsigned     HOLD_MAX      = 63;
    localparam int unsigned     HOLD_LIMIT_MS = 1000;
    localparam int              SETTLE_CYCLES = 8;
    localparam int              TAIL_CYCLES   = 20;
    localparam int              IDLE_PCT      = 27;

    typedef struct {
        logic signed [9:0] rms;
        logic signed [9:0] peak;
        logic [5:0]        hold;
        logic              changed;
    } reading_t;

    // Clock, reset and the ports of the meter.
    logic                            aclk        = 1'b0;
    logic                            aresetn     = 1'b0;
    logic                            cfg_wr_en   = 1'b0;
    logic [prl_pkg::INTERVAL_W-1:0]  cfg_wr_data = '0;
    logic                            s_tvalid    = 1'b0;
    logic                            s_tready;
    logic [15:0]                     s_tdata     = '0;   // [15:0] sample
    logic                            s_tuser     = 1'b0; // [0] cmd
    logic                            m_tvalid;
    logic                            m_tready    = 1'b0;
    logic [prl_pkg::M_TDATA_W-1:0]   m_tdata;            // [9:0] rms, [19:10] peak, [25:20] hold
    logic                            m_tuser;            // [0] changed

    // Model state of the meter.
    int unsigned     acc_peak     = 0;
    longint unsigned acc_energy   = 0;
    int unsigned     acc_count    = 0;
    int unsigned     hold_count   = 0;
    int              prev_rms     = -int'(FLOOR_MAG);
    int              prev_peak    = -int'(FLOOR_MAG);
    int unsigned     cur_interval = 50;

    reading_t expected_readings[$];
    int       err_count = 0;
    bit       idle_on   = 1'b1;

    always #2 aclk = ~aclk;

    peak_rms_level_meter DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    // Level below full scale in 1/8 dB, as a magnitude, for a power in units of 2^-30.
    function automatic int unsigned level_mag(input longint unsigned pwr);
        longint unsigned t, y, span;
        int unsigned     e, frac, i;
        if (pwr == 0) return FLOOR_MAG;
        e = 0;
        t = pwr;
        while (t > 1) begin
            t = t >> 1;
            e++;
        end
        if (e > FS_LOG2) return 0;
        y = (e >= 30) ? (pwr >> (e - 30)) : (pwr << (30 - e));
        // Fraction bits of log2 by repeated squaring of the Q1.30 mantissa.
        frac = 0;
        for (i = 0; i < 16; i++) begin
            y = (y * y) >> 30;
            frac = frac << 1;
            if (y >= (64'd1 << 31)) begin
                frac = frac | 1;
                y = y >> 1;
            end
        end
        span = 64'(FS_LOG2 - e) << 16;
        if (frac > span) return 0;
        span = span - frac;
        t = (span * LOG_SCALE_Q16 + (64'd1 << 31)) >> 32;
        return (t > FLOOR_MAG) ? FLOOR_MAG : int'(t);
    endfunction

    // A sample updates peak, energy and count, all saturating.
    task automatic accumulate(input logic [15:0] data);
        int          s;
        int unsigned mag;
        s = $signed(data);
        mag = (s < 0) ? -s : s;
        if (mag > acc_peak) acc_peak = mag;
        if (acc_energy + longint'(mag) * mag > ENERGY_MAX) acc_energy = ENERGY_MAX;
        else acc_energy = acc_energy + longint'(mag) * mag;
        if (acc_count < COUNT_MAX) acc_count++;
    endtask

    // A tick turns the accumulators into one reading and clears them.
    task automatic predict_tick();
        reading_t        rd;
        longint unsigned mean;
        int              rms_v, peak_v;
        int unsigned     hold_next;
        mean = (acc_count != 0) ? acc_energy / acc_count : 0;
        rms_v = (acc_count != 0) ? -int'(level_mag(mean)) : -int'(FLOOR_MAG);
        peak_v = -int'(level_mag(longint'(acc_peak) * acc_peak));

        // Overload hold: restart on full scale, else count while held, release after ~1 s.
        hold_next = hold_count;
        if (acc_peak >= 32768) hold_next = 1;
        else if (hold_next > 0 && hold_next < HOLD_MAX) hold_next++;
        if (longint'(hold_next) * cur_interval >= HOLD_LIMIT_MS) hold_next = 0;

        rd.rms = 10'(rms_v);
        rd.peak = 10'(peak_v);
        rd.hold = 6'(hold_next);
        rd.changed = (rms_v != prev_rms) || (peak_v != prev_peak) || (hold_next != hold_count);
        expected_readings.push_back(rd);

        prev_rms = rms_v;
        prev_peak = peak_v;
        hold_count = hold_next;
        acc_peak = 0;
        acc_energy = 0;
        acc_count = 0;
    endtask

    // Sends one item, with a random gap in front when idling is on.
    task automatic send_item(input logic cmd, input logic [15:0] data);
        if (idle_on && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < IDLE_PCT);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= data;
        do @(posedge aclk); while (!s_tready);
        if (cmd == CMD_TICK) predict_tick();
        else accumulate(data);
    endtask

    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        while (expected_readings.size() != 0) @(posedge aclk);
    endtask

    // Lets the sample pipeline empty before the meter is reconfigured.
    task automatic settle();
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_interval(input logic [prl_pkg::INTERVAL_W-1:0] value);
        cfg_wr_data <= value;
        cfg_wr_en <= 1'b1;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cur_interval = value;
    endtask

    function automatic logic [15:0] random_sample(input int shift, input int clip_pm);
        logic signed [15:0] v;
        if ($urandom_range(999) < clip_pm) return 16'h8000;
        v = $urandom;
        return v >>> shift;
    endfunction

    // Empty meter, zero power, near full scale, smallest samples, full scale and hold.
    task automatic test_directed_levels();
        send_item(CMD_TICK, 16'h0000);
        send_item(CMD_SAMPLE, 16'h0000);
        send_item(CMD_SAMPLE, 16'h0000);
        send_item(CMD_TICK, 16'hFFFF);
        send_item(CMD_SAMPLE, 16'h7FFF);
        send_item(CMD_TICK, 16'h0000);
        send_item(CMD_SAMPLE, 16'h0001);
        send_item(CMD_SAMPLE, 16'hFFFF);
        send_item(CMD_TICK, 16'h0000);
        send_item(CMD_SAMPLE, 16'h4000);
        send_item(CMD_SAMPLE, 16'hC000);
        send_item(CMD_SAMPLE, 16'h0400);
        send_item(CMD_TICK, 16'h0000);
        send_item(CMD_SAMPLE, 16'h8000);
        send_item(CMD_SAMPLE, 16'h8001);
        send_item(CMD_TICK, 16'h0000);
        send_item(CMD_SAMPLE, 16'h0100);
        send_item(CMD_TICK, 16'h0000);
        send_item(CMD_TICK, 16'h0000);
        send_item(CMD_TICK, 16'h0000);
        send_item(CMD_SAMPLE, 16'h5555);
        send_item(CMD_SAMPLE, 16'hAAAA);
        send_item(CMD_TICK, 16'h0000);
    endtask

    // Bursts of random samples, each closed by a tick, under one refresh interval.
    // Each phase opens with a full-scale sample so the hold counter runs under it.
    task automatic test_random_bursts(input logic [prl_pkg::INTERVAL_W-1:0] interval,
                                      input int n_items, input int max_burst,
                                      input int clip_pm, input bit with_idle);
        int sent, burst, shift;
        bit paused;
        settle();
        write_interval(interval);
        idle_on = with_idle;
        send_item(CMD_SAMPLE, 16'h8000);
        sent = 1;
        paused = 1'b0;
        while (sent < n_items) begin
            burst = $urandom_range(max_burst);
            shift = $urandom_range(12);
            repeat (burst) begin
                send_item(CMD_SAMPLE, random_sample(shift, clip_pm));
                sent++;
            end
            send_item(CMD_TICK, 16'($urandom));
            sent++;
            // Halfway through, stop sending until every reading is back.
            if (!paused && sent >= n_items / 2) begin
                paused = 1'b1;
                hold_until_drained();
            end
        end
    endtask

    // The receiver stalls at random while idling is on.
    always @(posedge aclk) begin
        m_tready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
    end

    // Each reading taken is compared with the oldest one predicted.
    always @(posedge aclk) begin : check_reading
        reading_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_readings.size() == 0) begin
                $error("unexpected result item: tdata %h tuser %b", m_tdata, m_tuser);
                err_count++;
            end else begin
                want = expected_readings.pop_front();
                if (m_tdata[9:0] !== want.rms) begin
                    $error("rms_db: expected %0d, got %0d", want.rms, $signed(m_tdata[9:0]));
                    err_count++;
                end
                if (m_tdata[19:10] !== want.peak) begin
                    $error("peak_db: expected %0d, got %0d",
                           want.peak, $signed(m_tdata[19:10]));
                    err_count++;
                end
                if (m_tdata[25:20] !== want.hold) begin
                    $error("overload: expected %0d, got %0d", want.hold, m_tdata[25:20]);
                    err_count++;
                end
                if (m_tuser !== want.changed) begin
                    $error("changed: expected %0d, got %0d", want.changed, m_tuser);
                    err_count++;
                end
            end
        end
    end

    // Test sequence.
    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_levels();
        test_random_bursts(14'd10000, 350, 40, 2, 1'b1);
        test_random_bursts(14'd20, 250, 3, 2, 1'b1);
        test_random_bursts(14'd0, 250, 3, 2, 1'b0);
        test_random_bursts(14'd16383, 200, 60, 3, 1'b1);
        test_random_bursts(14'($urandom_range(200, 20)), 200, 8, 2, 1'b1);
        hold_until_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (err_count == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end

    // Watchdog.
    initial begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

[peak_rms_level_meter.f]
+incdir+rtl
rtl/prl_pkg.sv
rtl/prl_div.sv
rtl/peak_rms_level_meter.sv
rtl/prl_chk.sv
tb/tb.sv
